// ===== rtl/ackws_pkg.sv =====
// ackws_pkg: fixed-point constants and the series used to build the tangent
// table of the ackermann wheel speed and servo core; no dependencies
package ackws_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HALF_TRACK   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SERVO_CENTER = 4'd1;

  localparam int K_W      = 15;
  localparam int CENTER_W = 12;
  localparam logic [K_W-1:0]      K_RESET      = 15'd4096;
  localparam logic [CENTER_W-1:0] CENTER_RESET = 12'd1500;

  // stream payload widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;
  localparam int SPEED_W    = 15;
  localparam int PULSE_W    = 12;

  // clamps
  localparam int SPEED_LIM = 4915;   // 1.2 in Q3.12
  localparam int ANGLE_LIM = 5243;   // 0.32 rad in Q2.14
  localparam int WHEEL_LIM = 14336;  // 3.5 in Q3.12
  localparam int PULSE_MIN = 800;
  localparam int PULSE_MAX = 2200;

  // internal widths
  localparam int V_W    = 13;  // clamped speed magnitude
  localparam int A_W    = 14;  // clamped angle, signed
  localparam int A2_W   = 25;
  localparam int A3_W   = 40;
  localparam int REM_W  = 14;  // remainder below twice the angle limit
  localparam int FRAC_W = 13;
  localparam int TAN_W  = 15;  // tan magnitude, unsigned Q16
  localparam int DIFF_W = 10;
  localparam int IP_W   = DIFF_W + FRAC_W;
  localparam int QE_W   = IP_W - FRAC_W + 1;
  localparam int POLY_W = 60;
  localparam int P30_W  = 32;
  localparam int PP_W   = 51;
  localparam int KT_W   = 30;
  localparam int KTR_W  = 16;
  localparam int F_W    = 17;
  localparam int WP_W   = 30;

  // reciprocal of the angle limit, 2^32 scale
  localparam int RECIP_W = 20;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / ANGLE_LIM);

  // servo polynomial, Q16 coefficients
  localparam logic signed [17:0] C3_Q16   = 18'sd41157;
  localparam logic [16:0]        C2_Q16   = 17'd83165;
  localparam logic signed [17:0] C1_Q16   = 18'sd116130;
  localparam logic signed [POLY_W-1:0] C0_TERM = 60'sd66 <<< 42;
  localparam logic signed [18:0] RATIO_Q8 = 19'sd162975;  // 636.62 in Q8

  // sine of an angle given in Q2.14, result in Q30, by integer series
  function automatic longint sin_q30(input longint a14);
    longint x, x2, x3, x4, x5, x6, x7;
    x  = a14 * 65536;
    x2 = (x * x) >> 30;
    x3 = (x2 * x) >> 30;
    x4 = (x2 * x2) >> 30;
    x5 = (x4 * x) >> 30;
    x6 = (x4 * x2) >> 30;
    x7 = (x6 * x) >> 30;
    return x - x3 / 6 + x5 / 120 - x7 / 5040;
  endfunction

  // cosine of an angle given in Q2.14, result in Q30, by integer series
  function automatic longint cos_q30(input longint a14);
    longint x, x2, x4, x6, x8;
    x  = a14 * 65536;
    x2 = (x * x) >> 30;
    x4 = (x2 * x2) >> 30;
    x6 = (x4 * x2) >> 30;
    x8 = (x4 * x4) >> 30;
    return 64'sd1073741824 - x2 / 2 + x4 / 24 - x6 / 720 + x8 / 40320;
  endfunction

endpackage

// ===== rtl/ackermann_wheel_speed_and_servo_core.sv =====
// ackermann_wheel_speed_and_servo_core: 13-stage pipeline from speed and
// steering command to wheel speeds and servo pulse; depends on ackws_pkg
//
// usage
//   s_axis carries one command per transaction: tdata[15:0] speed target
//   (signed Q3.12 m/s), tdata[31:16] steering angle (signed Q2.14 rad).
//   m_axis returns one result per command, in order: left and right wheel
//   speed (signed Q3.12, clamped to +-3.5) and the servo pulse (800..2200).
//   cfg carries register writes: index 0 half track over wheelbase (Q1.14),
//   index 1 servo centre pulse; other indexes are ignored. cfg_ready_o is
//   always high; write only while no command is in flight.
// latency and throughput
//   13 register stages; one command per cycle sustained while m_axis_tready
//   stays high, since a stalled m_axis holds the stages; latency is set by
//   the chain of multiplies: angle square and cube, the two reciprocal
//   divides of the tangent lookup, k*t and v*(1+-kt)
// reset
//   rst_ni clears all stage valid bits and loads the register defaults
//   (4096 and 1500). the tangent table is constant logic, no fill needed.
// back-pressure
//   each stage holds its item while the one after it is full and cannot
//   move on, so a stalled m_axis fills bubbles first; s_axis_tready drops
//   only when every stage holds a result.
module ackermann_wheel_speed_and_servo_core #(
  parameter int TAN_TABLE_DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ackws_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // speed_target, steer_angle
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ackws_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // left_wheel_speed,
                                                            // right_wheel_speed, servo_pulse
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ackws_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ackws_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ackws_pkg::*;

  localparam int NS    = 13;
  localparam int IDX_W = $clog2(TAN_TABLE_DEPTH + 1);
  localparam int POS_W = $clog2(ANGLE_LIM * TAN_TABLE_DEPTH + 1);
  localparam int QP_W  = POS_W + RECIP_W;

  // tangent samples over 0..0.32 rad, built at elaboration
  logic [TAN_W-1:0] tan_rom [TAN_TABLE_DEPTH+1];
  for (genvar gi = 0; gi <= TAN_TABLE_DEPTH; gi++) begin : g_tan
    localparam longint A14 = longint'(gi) * ANGLE_LIM / TAN_TABLE_DEPTH;
    localparam longint SN  = sin_q30(A14);
    localparam longint CS  = cos_q30(A14);
    localparam logic [TAN_W-1:0] TV = TAN_W'((SN * 65536 + CS / 2) / CS);
    assign tan_rom[gi] = TV;
  end

  // config registers
  logic [K_W-1:0]      k_q;
  logic [CENTER_W-1:0] center_q;

  // stage control
  logic [NS-1:0] vld_q;
  logic [NS-1:0] rdy;

  // delay taps that travel alongside the arithmetic
  logic [V_W-1:0]           vm_q    [0:10];
  logic                     vneg_q  [0:11];
  logic                     aneg_q  [0:9];
  logic signed [A_W-1:0]    a_q     [0:2];
  logic [A2_W-1:0]          a2_q    [1:2];
  logic [IDX_W-1:0]         est_q   [1:2];
  logic [FRAC_W-1:0]        frac_q  [3:4];
  logic [TAN_W-1:0]         lo_q    [4:7];
  logic [IP_W-1:0]          ip_q    [5:6];
  logic [QE_W-1:0]          qe_q    [6:7];
  logic [PULSE_W-1:0]       pulse_q [8:11];

  // per-stage payload
  logic [V_W-1:0]              s0_u_q;
  logic [POS_W-1:0]            s1_pos_q;
  logic [REM_W-1:0]            s2_rem_q;
  logic signed [A3_W-1:0]      s2_a3_q;
  logic [IDX_W-1:0]            s3_idx_q;
  logic signed [57:0]          s3_t3_q;
  logic [41:0]                 s3_t2_q;
  logic signed [31:0]          s3_t1_q;
  logic [DIFF_W-1:0]           s4_diff_q;
  logic signed [POLY_W-1:0]    s4_sa_q, s4_sb_q;
  logic signed [POLY_W-1:0]    s5_p58_q;
  logic signed [P30_W-1:0]     s6_p30_q;
  logic [REM_W-1:0]            s7_irem_q;
  logic signed [PP_W-1:0]      s7_pp_q;
  logic [TAN_W-1:0]            s8_tu_q;
  logic [KT_W-1:0]             s9_ktm_q;
  logic [F_W-1:0]              s10_fl_q, s10_fr_q;
  logic [WP_W-1:0]             s11_pl_q, s11_pr_q;
  logic [SPEED_W-1:0]          out_left_q, out_right_q;
  logic [PULSE_W-1:0]          out_pulse_q;

  // ---------------------------------------------------------------------
  // stage 0: clamp speed and angle, split into magnitude and sign
  // ---------------------------------------------------------------------
  logic signed [15:0]    spd_in, ang_in;
  logic signed [V_W:0]   v_c;
  logic signed [A_W-1:0] a_c;
  logic [V_W-1:0]        s0_vm_d, s0_u_d;

  always_comb begin
    spd_in = $signed(s_axis_tdata[15:0]);
    ang_in = $signed(s_axis_tdata[31:16]);
    if (spd_in > SPEED_LIM) begin
      v_c = (V_W+1)'(SPEED_LIM);
    end else if (spd_in < -SPEED_LIM) begin
      v_c = (V_W+1)'(-SPEED_LIM);
    end else begin
      v_c = (V_W+1)'(spd_in);
    end
    if (ang_in > ANGLE_LIM) begin
      a_c = A_W'(ANGLE_LIM);
    end else if (ang_in < -ANGLE_LIM) begin
      a_c = A_W'(-ANGLE_LIM);
    end else begin
      a_c = A_W'(ang_in);
    end
    s0_vm_d = v_c[V_W] ? V_W'(-v_c) : V_W'(v_c);
    s0_u_d  = a_c[A_W-1] ? V_W'(-a_c) : V_W'(a_c);
  end

  // ---------------------------------------------------------------------
  // stage 1: angle squared; table position and first guess of its index
  // ---------------------------------------------------------------------
  logic [A2_W-1:0]  s1_a2_d;
  logic [POS_W-1:0] s1_pos_d;
  logic [QP_W-1:0]  s1_qprod;
  logic [IDX_W-1:0] s1_est_d;

  always_comb begin
    s1_a2_d  = A2_W'(a_q[0] * a_q[0]);
    s1_pos_d = POS_W'(s0_u_q * TAN_TABLE_DEPTH);
    s1_qprod = QP_W'(s1_pos_d) * QP_W'(RECIP);
    s1_est_d = s1_qprod[32 +: IDX_W];
  end

  // ---------------------------------------------------------------------
  // stage 2: remainder of the index guess; angle cubed
  // ---------------------------------------------------------------------
  logic [POS_W-1:0]       s2_rem_full;
  logic signed [A3_W-1:0] s2_a3_d;

  always_comb begin
    s2_rem_full = s1_pos_q - POS_W'(est_q[1] * ANGLE_LIM);
    s2_a3_d     = $signed({1'b0, a2_q[1]}) * a_q[1];
  end

  // ---------------------------------------------------------------------
  // stage 3: index correction; polynomial term products
  // ---------------------------------------------------------------------
  logic                s3_ge;
  logic [IDX_W-1:0]    s3_idx_d;
  logic [FRAC_W-1:0]   s3_frac_d;
  logic signed [57:0]  s3_t3_d;
  logic [41:0]         s3_t2_d;
  logic signed [31:0]  s3_t1_d;

  always_comb begin
    s3_ge     = s2_rem_q >= REM_W'(ANGLE_LIM);
    s3_idx_d  = est_q[2] + IDX_W'(s3_ge);
    s3_frac_d = s3_ge ? FRAC_W'(s2_rem_q - REM_W'(ANGLE_LIM)) : FRAC_W'(s2_rem_q);
    s3_t3_d   = s2_a3_q * C3_Q16;
    s3_t2_d   = a2_q[2] * C2_Q16;
    s3_t1_d   = a_q[2] * C1_Q16;
  end

  // ---------------------------------------------------------------------
  // stage 4: table read; polynomial partial sums
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0]         s4_hi_idx;
  logic [TAN_W-1:0]         s4_lo_d;
  logic [DIFF_W-1:0]        s4_diff_d;
  logic signed [POLY_W-1:0] s4_sa_d, s4_sb_d;

  always_comb begin
    // last sample has no successor: slope forced to zero
    s4_hi_idx = (s3_idx_q == IDX_W'(TAN_TABLE_DEPTH)) ? s3_idx_q : s3_idx_q + 1'b1;
    s4_lo_d   = tan_rom[s3_idx_q];
    s4_diff_d = DIFF_W'(tan_rom[s4_hi_idx] - s4_lo_d);
    s4_sa_d   = $signed(POLY_W'({s3_t2_q, 14'b0})) - POLY_W'(s3_t3_q);
    s4_sb_d   = C0_TERM - (POLY_W'(s3_t1_q) <<< 28);
  end

  // ---------------------------------------------------------------------
  // stage 5: interpolation product; polynomial total
  // ---------------------------------------------------------------------
  logic [IP_W-1:0]          s5_ip_d;
  logic signed [POLY_W-1:0] s5_p58_d;

  always_comb begin
    s5_ip_d  = s4_diff_q * frac_q[4];
    s5_p58_d = s4_sa_q + s4_sb_q;
  end

  // ---------------------------------------------------------------------
  // stage 6: quotient guess of the interpolation; polynomial to Q30
  // ---------------------------------------------------------------------
  logic [IP_W+RECIP_W-1:0]  s6_qprod;
  logic [QE_W-1:0]          s6_qe_d;
  logic signed [POLY_W-1:0] s6_rnd;
  logic signed [POLY_W-1:0] s6_sum;
  logic signed [P30_W-1:0]  s6_p30_d;

  always_comb begin
    s6_qprod = ip_q[5] * RECIP;
    s6_qe_d  = s6_qprod[32 +: QE_W];
    // half away from zero: negative values take half minus one before the shift
    s6_rnd   = s5_p58_q[POLY_W-1] ? POLY_W'((64'sd1 <<< 27) - 1) : POLY_W'(64'sd1 <<< 27);
    s6_sum   = s5_p58_q + s6_rnd;
    s6_p30_d = P30_W'(s6_sum >>> 28);
  end

  // ---------------------------------------------------------------------
  // stage 7: interpolation remainder; polynomial scaled to pulse units
  // ---------------------------------------------------------------------
  logic [IP_W-1:0]        s7_irem_full;
  logic signed [PP_W-1:0] s7_pp_d;

  always_comb begin
    s7_irem_full = ip_q[6] - IP_W'(qe_q[6] * ANGLE_LIM);
    s7_pp_d      = s6_p30_q * RATIO_Q8;
  end

  // ---------------------------------------------------------------------
  // stage 8: tan magnitude; servo pulse with centre and clamp
  // ---------------------------------------------------------------------
  logic               s8_ge;
  logic [TAN_W-1:0]   s8_tu_d;
  logic signed [52:0] s8_total;
  logic [12:0]        s8_raw;
  logic [PULSE_W-1:0] s8_pulse_d;

  always_comb begin
    s8_ge    = s7_irem_q >= REM_W'(ANGLE_LIM);
    s8_tu_d  = lo_q[7] + TAN_W'(qe_q[7]) + TAN_W'(s8_ge);
    s8_total = $signed(53'({center_q, 38'b0})) + 53'(s7_pp_q);
    s8_raw   = s8_total[52] ? 13'd0 : s8_total[50:38];
    if (s8_raw < 13'(PULSE_MIN)) begin
      s8_pulse_d = PULSE_W'(PULSE_MIN);
    end else if (s8_raw > 13'(PULSE_MAX)) begin
      s8_pulse_d = PULSE_W'(PULSE_MAX);
    end else begin
      s8_pulse_d = PULSE_W'(s8_raw);
    end
  end

  // ---------------------------------------------------------------------
  // stages 9 to 12: k*t, wheel factors, wheel products, rounding
  // ---------------------------------------------------------------------
  logic [KT_W-1:0]  s9_ktm_d;
  logic [KTR_W-1:0] s10_ktr;
  logic [F_W-1:0]   s10_fl_d, s10_fr_d;
  logic [WP_W-1:0]  s11_pl_d, s11_pr_d;
  logic [WP_W:0]    s12_lsum, s12_rsum;
  logic [SPEED_W-1:0] s12_wl, s12_wr, s12_left_d, s12_right_d;

  always_comb begin
    s9_ktm_d = s8_tu_q * k_q;
    s10_ktr  = KTR_W'((s9_ktm_q + KT_W'(8192)) >> 14);
    // negative angle flips the sign of k*t
    s10_fl_d = aneg_q[9] ? F_W'(65536) + F_W'(s10_ktr) : F_W'(65536) - F_W'(s10_ktr);
    s10_fr_d = aneg_q[9] ? F_W'(65536) - F_W'(s10_ktr) : F_W'(65536) + F_W'(s10_ktr);
    s11_pl_d = vm_q[10] * s10_fl_q;
    s11_pr_d = vm_q[10] * s10_fr_q;
    s12_lsum = (WP_W+1)'(s11_pl_q) + (WP_W+1)'(32768);
    s12_rsum = (WP_W+1)'(s11_pr_q) + (WP_W+1)'(32768);
    s12_wl   = s12_lsum[WP_W:16];
    s12_wr   = s12_rsum[WP_W:16];
    if (s12_wl > SPEED_W'(WHEEL_LIM)) s12_wl = SPEED_W'(WHEEL_LIM);
    if (s12_wr > SPEED_W'(WHEEL_LIM)) s12_wr = SPEED_W'(WHEEL_LIM);
    s12_left_d  = vneg_q[11] ? SPEED_W'(-s12_wl) : s12_wl;
    s12_right_d = vneg_q[11] ? SPEED_W'(-s12_wr) : s12_wr;
  end

  // ---------------------------------------------------------------------
  // handshake: a stage may load when it is empty or its content moves on
  // ---------------------------------------------------------------------
  always_comb begin
    rdy[NS-1] = !vld_q[NS-1] || m_axis_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      vm_q[0]   <= s0_vm_d;
      vneg_q[0] <= v_c[V_W];
      aneg_q[0] <= a_c[A_W-1];
      a_q[0]    <= a_c;
      s0_u_q    <= s0_u_d;
    end
    if (rdy[1]) begin
      a_q[1]   <= a_q[0];
      a2_q[1]  <= s1_a2_d;
      s1_pos_q <= s1_pos_d;
      est_q[1] <= s1_est_d;
    end
    if (rdy[2]) begin
      a_q[2]   <= a_q[1];
      a2_q[2]  <= a2_q[1];
      est_q[2] <= est_q[1];
      s2_rem_q <= s2_rem_full[REM_W-1:0];
      s2_a3_q  <= s2_a3_d;
    end
    if (rdy[3]) begin
      s3_idx_q  <= s3_idx_d;
      frac_q[3] <= s3_frac_d;
      s3_t3_q   <= s3_t3_d;
      s3_t2_q   <= s3_t2_d;
      s3_t1_q   <= s3_t1_d;
    end
    if (rdy[4]) begin
      lo_q[4]   <= s4_lo_d;
      s4_diff_q <= s4_diff_d;
      frac_q[4] <= frac_q[3];
      s4_sa_q   <= s4_sa_d;
      s4_sb_q   <= s4_sb_d;
    end
    if (rdy[5]) begin
      lo_q[5]  <= lo_q[4];
      ip_q[5]  <= s5_ip_d;
      s5_p58_q <= s5_p58_d;
    end
    if (rdy[6]) begin
      lo_q[6]  <= lo_q[5];
      ip_q[6]  <= ip_q[5];
      qe_q[6]  <= s6_qe_d;
      s6_p30_q <= s6_p30_d;
    end
    if (rdy[7]) begin
      lo_q[7]   <= lo_q[6];
      qe_q[7]   <= qe_q[6];
      s7_irem_q <= s7_irem_full[REM_W-1:0];
      s7_pp_q   <= s7_pp_d;
    end
    if (rdy[8]) begin
      s8_tu_q    <= s8_tu_d;
      pulse_q[8] <= s8_pulse_d;
    end
    if (rdy[9]) begin
      s9_ktm_q   <= s9_ktm_d;
      pulse_q[9] <= pulse_q[8];
    end
    if (rdy[10]) begin
      s10_fl_q    <= s10_fl_d;
      s10_fr_q    <= s10_fr_d;
      pulse_q[10] <= pulse_q[9];
    end
    if (rdy[11]) begin
      s11_pl_q    <= s11_pl_d;
      s11_pr_q    <= s11_pr_d;
      pulse_q[11] <= pulse_q[10];
    end
    if (rdy[12]) begin
      out_left_q  <= s12_left_d;
      out_right_q <= s12_right_d;
      out_pulse_q <= pulse_q[11];
    end
    // sign and magnitude taps
    for (int i = 1; i <= 10; i++) begin
      if (rdy[i]) vm_q[i] <= vm_q[i-1];
    end
    for (int i = 1; i <= 11; i++) begin
      if (rdy[i]) vneg_q[i] <= vneg_q[i-1];
    end
    for (int i = 1; i <= 9; i++) begin
      if (rdy[i]) aneg_q[i] <= aneg_q[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // register writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= K_RESET;
      center_q <= CENTER_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_HALF_TRACK:   k_q      <= cfg_data_i[K_W-1:0];
        CFG_IDX_SERVO_CENTER: center_q <= cfg_data_i[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NS-1];
  assign m_axis_tdata  = {(OUT_DATA_W - 2*SPEED_W - PULSE_W)'(0),
                          out_pulse_q, out_right_q, out_left_q};

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[41:30] >= 12'(PULSE_MIN)) &&
                      (m_axis_tdata[41:30] <= 12'(PULSE_MAX)))
    else $error("servo pulse outside clamp");

  a_wheel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) >= -WHEEL_LIM) &&
                      ($signed(m_axis_tdata[14:0]) <= WHEEL_LIM) &&
                      ($signed(m_axis_tdata[29:15]) >= -WHEEL_LIM) &&
                      ($signed(m_axis_tdata[29:15]) <= WHEEL_LIM))
    else $error("wheel speed outside clamp");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> ($countones(vld_q) == NS))
    else $error("input blocked while pipeline has a bubble");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted transaction not held in first stage");

  a_frac_below_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (frac_q[3] < FRAC_W'(ANGLE_LIM)))
    else $error("table index correction left remainder too large");

endmodule

// ===== dv/tb_ackermann_wheel_speed_and_servo_core.sv =====
// testbench for ackermann_wheel_speed_and_servo_core: directed and random steering commands
// checked against a fixed-point predictor held in a scoreboard class
// depends on ackws_pkg and the core rtl
`timescale 1ns / 100ps

module tb_ackermann_wheel_speed_and_servo_core;

  import ackws_pkg::*;

  localparam int TAN_DEPTH       = 256;
  localparam int RAND_PER_PHASE  = 141;
  localparam int N_PHASES        = 8;
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off in the pressure phase
  localparam int SETTLE_CYCLES   = 32;    // well past the pipeline depth
  localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no transaction on any channel
  localparam int PRESSURE_PHASE  = 4;
  localparam int SPARE_PHASE     = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'hF;  // not decoded by the core

  // idle modes: sender idle and receiver stall, percent of cycles
  localparam int MODE_NONE = 0;
  localparam int MODE_SEND = 1;
  localparam int MODE_RECV = 2;
  localparam int MODE_BOTH = 3;

  // per phase: track ratio, centre write data, idle mode
  // phase 0 runs on reset values; the centre write of 32767 is masked to 4095
  localparam int PH_K[N_PHASES]    = '{4096, 0, 32767, 8192, 12000, 1, 20000, 5000};
  localparam int PH_C[N_PHASES]    = '{1500, 800, 2200, 32767, 0, 1500, 1234, 1900};
  localparam int PH_MODE[N_PHASES] = '{MODE_NONE, MODE_SEND, MODE_RECV, MODE_BOTH,
                                       MODE_NONE, MODE_SEND, MODE_RECV, MODE_BOTH};

  // directed commands: field extremes, clamp edges, zero angle, small angles
  localparam int N_DIRECTED = 23;
  localparam int DIR_SPEED[N_DIRECTED] = '{
    0, 32767, -32768, 4915, -4915, 4916, -4916, 4915, 4915, 32767, -32768, 32767,
    -32768, 4096, 4096, -4096, 100, 4915, -1, 1, 0, 2048, 21845};
  localparam int DIR_ANGLE[N_DIRECTED] = '{
    0, 0, 0, 0, 0, 5243, -5243, 5244, -5244, 32767, -32768, -32768,
    32767, 1, -1, 2621, -2621, 5242, 5243, -5243, 5243, -21846, 21845};

  class ackws_scoreboard;

    typedef struct {
      logic [14:0] left;
      logic [14:0] right;
      logic [11:0] pulse;
    } wheel_result_t;

    localparam int     DEPTH       = TAN_DEPTH;
    localparam longint SPEED_CLAMP = 4915;
    localparam longint ANGLE_CLAMP = 5243;
    localparam longint WHEEL_CLAMP = 14336;
    localparam longint PULSE_LO    = 800;
    localparam longint PULSE_HI    = 2200;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint CUBE_Q16    = 41157;
    localparam longint SQUARE_Q16  = 83165;
    localparam longint LINEAR_Q16  = 116130;
    localparam longint OFFSET_Q16  = 66;
    localparam longint US_PER_RAD  = 162975;  // 636.62 in Q8

    longint        tan_lut[DEPTH+1];
    logic [14:0]   track_ratio;
    logic [11:0]   centre_pulse;
    wheel_result_t expected_q[$];
    int            errors;
    int            commands;
    int            results;

    function new();
      longint x, x2, x3, x4, x5, x6, x7, x8, s, c;
      for (int i = 0; i <= DEPTH; i++) begin
        x  = (longint'(i) * ANGLE_CLAMP / DEPTH) * 65536;
        x2 = (x * x) >>> 30;
        x3 = (x2 * x) >>> 30;
        x4 = (x2 * x2) >>> 30;
        x5 = (x4 * x) >>> 30;
        x6 = (x4 * x2) >>> 30;
        x7 = (x6 * x) >>> 30;
        x8 = (x4 * x4) >>> 30;
        s  = x - x3 / 6 + x5 / 120 - x7 / 5040;
        c  = ONE_Q30 - x2 / 2 + x4 / 24 - x6 / 720 + x8 / 40320;
        tan_lut[i] = (s * 65536 + c / 2) / c;
      end
      track_ratio  = ackws_pkg::K_RESET;
      centre_pulse = ackws_pkg::CENTER_RESET;
      errors   = 0;
      commands = 0;
      results  = 0;
    endfunction

    // round half away from zero
    static function longint round_shr(longint x, int sh);
      longint half;
      half = longint'(1) << (sh - 1);
      if (x >= 0) return (x + half) >>> sh;
      return -((-x + half) >>> sh);
    endfunction

    static function longint sat(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function void write_reg(logic [ackws_pkg::CFG_IDX_W-1:0] idx,
                            logic [ackws_pkg::CFG_DATA_W-1:0] data);
      if (idx == ackws_pkg::CFG_IDX_HALF_TRACK) track_ratio = data[14:0];
      else if (idx == ackws_pkg::CFG_IDX_SERVO_CENTER) centre_pulse = data[11:0];
    endfunction

    // interpolated tangent in Q16, sign of the angle
    function longint tangent(longint a);
      longint u, pos, idx, frac, t;
      u    = a < 0 ? -a : a;
      pos  = u * DEPTH;
      idx  = pos / ANGLE_CLAMP;
      frac = pos % ANGLE_CLAMP;
      if (idx >= DEPTH) t = tan_lut[DEPTH];
      else t = tan_lut[idx] + (tan_lut[idx+1] - tan_lut[idx]) * frac / ANGLE_CLAMP;
      return a < 0 ? -t : t;
    endfunction

    function void note_command(logic [31:0] data);
      longint v, a, t, kt, lw, rw, a2, a3, p58, p30, total, pulse;
      wheel_result_t r;
      v  = sat(longint'($signed(data[15:0])), -SPEED_CLAMP, SPEED_CLAMP);
      a  = sat(longint'($signed(data[31:16])), -ANGLE_CLAMP, ANGLE_CLAMP);
      t  = tangent(a);
      kt = round_shr(longint'(track_ratio) * t, 14);
      lw = sat(round_shr(v * (65536 - kt), 16), -WHEEL_CLAMP, WHEEL_CLAMP);
      rw = sat(round_shr(v * (65536 + kt), 16), -WHEEL_CLAMP, WHEEL_CLAMP);
      a2 = a * a;
      a3 = a2 * a;
      p58 = -a3 * CUBE_Q16 + a2 * SQUARE_Q16 * 16384
            - a * LINEAR_Q16 * (longint'(1) << 28) + OFFSET_Q16 * (longint'(1) << 42);
      p30   = round_shr(p58, 28);
      total = longint'(centre_pulse) * (longint'(1) << 38) + p30 * US_PER_RAD;
      pulse = total < 0 ? 0 : (total >>> 38);
      pulse = sat(pulse, PULSE_LO, PULSE_HI);
      r.left  = lw[14:0];
      r.right = rw[14:0];
      r.pulse = pulse[11:0];
      expected_q.push_back(r);
      commands++;
    endfunction

    function void check_result(logic [47:0] data);
      wheel_result_t e;
      results++;
      if (expected_q.size() == 0) begin
        $error("result transaction with no command outstanding: %h", data);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data[14:0] !== e.left) begin
        $error("left_wheel_speed mismatch: expected %0d, actual %0d",
               $signed(e.left), $signed(data[14:0]));
        errors++;
      end
      if (data[29:15] !== e.right) begin
        $error("right_wheel_speed mismatch: expected %0d, actual %0d",
               $signed(e.right), $signed(data[29:15]));
        errors++;
      end
      if (data[41:30] !== e.pulse) begin
        $error("servo_pulse mismatch: expected %0d, actual %0d", e.pulse, data[41:30]);
        errors++;
      end
      if (data[47:42] !== 6'd0) begin
        $error("tdata padding mismatch: expected %0d, actual %0d", 0, data[47:42]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  s_axis_tvalid  = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata   = '0;  // speed_target, steer_angle
  logic                  m_axis_tvalid;
  logic                  m_axis_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // left_wheel_speed, right_wheel_speed, servo_pulse
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  ackws_scoreboard wheel_sb = new();

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_go        = 1'b0;
  bit  hold_taken     = 1'b0;
  int  hold_left      = 0;
  int  quiet_cycles   = 0;
  int  input_stalls   = 0;

  ackermann_wheel_speed_and_servo_core #(
    .TAN_TABLE_DEPTH(TAN_DEPTH)
  ) u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // reset held low from the start, released once
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // result side: random stall, or a long hold-off once asked for
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitors: register writes, accepted commands, accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) wheel_sb.write_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) wheel_sb.note_command(s_axis_tdata);
      if (s_axis_tvalid && !s_axis_tready) input_stalls++;
      if (m_axis_tvalid && m_axis_tready) wheel_sb.check_result(m_axis_tdata);
    end
  end

  // watchdog: any transaction on any channel counts as progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, wheel_sb.pending());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // one command transaction; valid stays up across back-to-back commands
  task automatic send_cmd(input logic [15:0] speed, input logic [15:0] angle);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {angle, speed};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // one register write; valid drops after the last write of a group
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit last_write);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last_write) cfg_valid_i <= 1'b0;
  endtask

  // waits on the clock first so the monitor has noted the last accepted command
  task automatic wait_drained();
    @(posedge clk_i);
    while (wheel_sb.pending() != 0) @(posedge clk_i);
  endtask

  // mostly commands in and around the clamp window, some anywhere in 16 bits
  function automatic logic [15:0] pick_speed();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) return 16'($urandom());
    if (sel < 32) return ($urandom_range(1)) ? 16'sd4915 : -16'sd4915;
    return 16'($signed($urandom_range(10400)) - 5200);
  endfunction

  function automatic logic [15:0] pick_angle();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) return 16'($urandom());
    if (sel < 30) return ($urandom_range(1)) ? 16'sd5243 : -16'sd5243;
    if (sel < 38) return 16'($signed($urandom_range(64)) - 32);
    return 16'($signed($urandom_range(11000)) - 5500);
  endfunction

  initial begin
    wait (rst_ni);
    @(posedge clk_i);

    for (int p = 0; p < N_PHASES; p++) begin
      // registers only change with nothing in flight
      if (p > 0) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
        if (p == SPARE_PHASE) write_reg(CFG_IDX_SPARE, 15'h2AD5, 1'b0);
        write_reg(CFG_IDX_HALF_TRACK, CFG_DATA_W'(PH_K[p]), 1'b0);
        write_reg(CFG_IDX_SERVO_CENTER, CFG_DATA_W'(PH_C[p]), 1'b1);
      end

      send_idle_pct  <= (PH_MODE[p] == MODE_SEND) ? 80 : (PH_MODE[p] == MODE_BOTH) ? 19 : 0;
      recv_stall_pct <= (PH_MODE[p] == MODE_RECV) ? 80 : (PH_MODE[p] == MODE_BOTH) ? 19 : 0;

      if (p == 0) begin
        for (int i = 0; i < N_DIRECTED; i++)
          send_cmd(16'(DIR_SPEED[i]), 16'(DIR_ANGLE[i]));
      end

      // sender keeps offering while the result side holds off
      if (p == PRESSURE_PHASE) hold_go <= 1'b1;

      for (int i = 0; i < RAND_PER_PHASE; i++) send_cmd(pick_speed(), pick_angle());
    end
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d commands and %0d results over %0d register settings,",
             wheel_sb.commands, wheel_sb.results, N_PHASES);
    $display("with %0d cycles of input back-pressure and %0d field mismatches",
             input_stalls, wheel_sb.errors);
    if (wheel_sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
